### hdl/stk_pkg.sv
// Shared constants, types and register map of the score threshold top-K selector.
// Used by stk_cell, stk_edge_scale and score_threshold_top_k_select_unit.
// Depends on nothing.
package stk_pkg;

    // store depth and derived widths
    localparam int MAX_KEPT = 8;
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);

    // field widths
    localparam int SCORE_W = 16;
    localparam int EDGE_W  = 16;
    localparam int DIM_W   = 13;
    localparam int PIX_W   = 14;
    localparam int BOX_W   = 4 * EDGE_W;
    localparam int PROD_W  = EDGE_W + DIM_W + 1;
    localparam int FRAC_W  = 14;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_SCORE_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH     = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT    = 2'd2;

    localparam logic [SCORE_W-1:0] THRESH_RST = 16'd26214;
    localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd1920;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd1080;

    // one stored candidate: edges packed left, top, right, bottom from bit 0
    typedef struct packed {
        logic [BOX_W-1:0]   box;
        logic [SCORE_W-1:0] score;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;    // insert the candidate
        logic shift;  // move every entry one place toward the head
    } t_cell_ctl;

endpackage

### hdl/stk_cell.sv
// One cell of the sorted insertion chain: holds one candidate entry.
// Depends on stk_pkg for the entry and control types.
module stk_cell (
    input  logic                i_clk,
    input  stk_pkg::t_cell_ctl  i_ctl,
    input  stk_pkg::t_entry     i_cand,
    input  logic                i_valid,
    input  logic                i_prev_keep,
    input  stk_pkg::t_entry     i_prev,
    input  stk_pkg::t_entry     i_next,
    output logic                o_keep,
    output stk_pkg::t_entry     o_entry
);

    stk_pkg::t_entry r_entry;
    stk_pkg::t_entry n_entry;

    // a valid entry with an equal or better score stays ahead of the candidate
    assign o_keep  = i_valid && (r_entry.score >= i_cand.score);
    assign o_entry = r_entry;

    // shift toward head on drain; on insert take candidate or predecessor
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_next;
        end else if (i_ctl.ins && !o_keep) begin
            n_entry = i_prev_keep ? i_cand : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### hdl/stk_edge_scale.sv
// Scales one signed Q2.14 box edge by a frame dimension into whole pixels.
// Truncates toward zero and saturates to the pixel range. Depends on stk_pkg.
module stk_edge_scale (
    input  logic signed [stk_pkg::EDGE_W-1:0] i_edge,
    input  logic        [stk_pkg::DIM_W-1:0]  i_dim,
    output logic signed [stk_pkg::PIX_W-1:0]  o_pix
);

    localparam int QW = stk_pkg::PROD_W - stk_pkg::FRAC_W;
    localparam logic signed [QW-1:0] PIX_MAX = QW'(2 ** (stk_pkg::PIX_W - 1) - 1);
    localparam logic signed [QW-1:0] PIX_MIN = -QW'(2 ** (stk_pkg::PIX_W - 1));

    logic signed [stk_pkg::PROD_W-1:0] prod;
    logic signed [stk_pkg::PROD_W-1:0] bias;
    logic signed [stk_pkg::PROD_W-1:0] adj;
    logic signed [QW-1:0]              quo;

    // signed product, then bias negatives so the shift rounds toward zero
    always_comb begin
        prod = stk_pkg::PROD_W'(i_edge) * $signed({1'b0, i_dim});
        bias = prod[stk_pkg::PROD_W-1]
             ? stk_pkg::PROD_W'((2 ** stk_pkg::FRAC_W) - 1) : '0;
        adj  = prod + bias;
        quo  = adj[stk_pkg::PROD_W-1:stk_pkg::FRAC_W];
        if (quo > PIX_MAX) begin
            o_pix = PIX_MAX[stk_pkg::PIX_W-1:0];
        end else if (quo < PIX_MIN) begin
            o_pix = PIX_MIN[stk_pkg::PIX_W-1:0];
        end else begin
            o_pix = quo[stk_pkg::PIX_W-1:0];
        end
    end

endmodule

### hdl/score_threshold_top_k_select_unit.sv
// Top level of the score threshold top-K selector: stream ports, APB registers,
// the chain of stk_cell entries and the drain path. Depends on stk_pkg,
// stk_cell and stk_edge_scale.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+-----------------------------------------
//  s_axis    | in  | tvalid / tready         | tdata 80b, tlast = last_candidate
//  m_axis    | out | tvalid / tready         | tdata 72b, tuser = found, tlast = last_result
//  apb       | in  | psel / penable / pready | paddr 4b, pwdata / prdata 32b
//
// Candidates are taken while idle; the sorted insert into the cell chain is one
// compare per cell, so candidates stream back to back while collecting.
// After the last candidate the block drains: one result per cycle from the head
// cell (at least one result), and takes no candidate until the final result is
// loaded into the output register. Output stalls hold the drain in place.
// Reset empties the store (count to zero) and restores the register defaults.
module score_threshold_top_k_select_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // candidate stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [15:0] score, [31:16] box_left, [47:32] box_top, [63:48] box_right,
    // [79:64] box_bottom
    input  logic [79:0]                 s_axis_tdata,
    input  logic                        s_axis_tlast,
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [15:0] det_score, [29:16] pix_left, [43:30] pix_top, [57:44] pix_right,
    // [71:58] pix_bottom
    output logic [71:0]                 m_axis_tdata,
    // [0] found
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stk_pkg::APB_AW-1:0]  paddr,
    input  logic [stk_pkg::APB_DW-1:0]  pwdata,
    output logic [stk_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    localparam int N = stk_pkg::MAX_KEPT;

    t_state r_state;
    t_state n_state;
    logic [stk_pkg::CNT_W-1:0] r_count;
    logic [stk_pkg::CNT_W-1:0] n_count;

    logic [stk_pkg::SCORE_W-1:0] r_thresh;
    logic [stk_pkg::DIM_W-1:0]   r_width;
    logic [stk_pkg::DIM_W-1:0]   r_height;

    logic                            r_out_valid;
    logic                            r_out_found;
    logic                            r_out_last;
    logic [stk_pkg::SCORE_W-1:0]     r_out_score;
    logic [4*stk_pkg::PIX_W-1:0]     r_out_pix;

    stk_pkg::t_entry    cand;
    stk_pkg::t_cell_ctl ctl;
    stk_pkg::t_entry    cell_q    [N];
    logic [N-1:0]       cell_keep;
    logic [N-1:0]       cell_valid;

    logic in_acc;
    logic wr_acc;
    logic drain_load;
    logic head_valid;

    logic signed [stk_pkg::PIX_W-1:0] pix [4];

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign wr_acc = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= stk_pkg::THRESH_RST;
            r_width  <= stk_pkg::WIDTH_RST;
            r_height <= stk_pkg::HEIGHT_RST;
        end else if (wr_acc) begin
            case (paddr[3:2])
                stk_pkg::REG_SCORE_THRESHOLD: r_thresh <= pwdata[stk_pkg::SCORE_W-1:0];
                stk_pkg::REG_FRAME_WIDTH:     r_width  <= pwdata[stk_pkg::DIM_W-1:0];
                stk_pkg::REG_FRAME_HEIGHT:    r_height <= pwdata[stk_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            stk_pkg::REG_SCORE_THRESHOLD: prdata = stk_pkg::APB_DW'(r_thresh);
            stk_pkg::REG_FRAME_WIDTH:     prdata = stk_pkg::APB_DW'(r_width);
            stk_pkg::REG_FRAME_HEIGHT:    prdata = stk_pkg::APB_DW'(r_height);
            default:                      prdata = '0;
        endcase
    end

    // ---------------- input side ----------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cand.score    = s_axis_tdata[15:0];
    assign cand.box      = s_axis_tdata[79:16];

    // drain pops the head whenever the output slot is free or being emptied
    assign drain_load = (r_state == ST_DRAIN) && (!r_out_valid || m_axis_tready);
    assign head_valid = (r_count != '0);

    assign ctl.ins   = in_acc && (cand.score > r_thresh);
    assign ctl.shift = drain_load && head_valid;

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < N; i++) begin : g_cell
        assign cell_valid[i] = (stk_pkg::CNT_W'(i) < r_count);
        if (i == 0) begin : g_head
            stk_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_cand      (cand),
                .i_valid     (cell_valid[i]),
                .i_prev_keep (1'b1),
                .i_prev      (cand),
                .i_next      ((N > 1) ? cell_q[(N > 1) ? 1 : 0] : cell_q[0]),
                .o_keep      (cell_keep[i]),
                .o_entry     (cell_q[i])
            );
        end else if (i == N - 1) begin : g_tail
            stk_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_cand      (cand),
                .i_valid     (cell_valid[i]),
                .i_prev_keep (cell_keep[i-1]),
                .i_prev      (cell_q[i-1]),
                .i_next      (cell_q[i]),
                .o_keep      (cell_keep[i]),
                .o_entry     (cell_q[i])
            );
        end else begin : g_mid
            stk_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_cand      (cand),
                .i_valid     (cell_valid[i]),
                .i_prev_keep (cell_keep[i-1]),
                .i_prev      (cell_q[i-1]),
                .i_next      (cell_q[i+1]),
                .o_keep      (cell_keep[i]),
                .o_entry     (cell_q[i])
            );
        end
    end

    // ---------------- fill count and sequencing ----------------
    always_comb begin
        n_count = r_count;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (ctl.ins && (r_count != stk_pkg::CNT_W'(N))) begin
                    n_count = r_count + 1'b1;
                end
                if (in_acc && s_axis_tlast) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_load) begin
                    if (head_valid) begin
                        n_count = r_count - 1'b1;
                    end
                    if (r_count <= stk_pkg::CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // ---------------- edge scaling of the head entry ----------------
    for (genvar e = 0; e < 4; e++) begin : g_scale
        stk_edge_scale u_scale (
            .i_edge (cell_q[0].box[e*stk_pkg::EDGE_W +: stk_pkg::EDGE_W]),
            .i_dim  ((e % 2 == 0) ? r_width : r_height),
            .o_pix  (pix[e])
        );
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (drain_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // empty frame gives one all-zero result with found low
    always_ff @(posedge i_clk) begin
        if (drain_load) begin
            r_out_found <= head_valid;
            r_out_last  <= (r_count <= stk_pkg::CNT_W'(1));
            r_out_score <= head_valid ? cell_q[0].score : '0;
            r_out_pix   <= head_valid ? {pix[3], pix[2], pix[1], pix[0]} : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pix, r_out_score};
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tlast  = r_out_last;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stk_pkg::CNT_W'(N))
        else $error("fill count above store depth");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (N > 1 && r_count >= stk_pkg::CNT_W'(2))
            |-> (cell_q[0].score >= cell_q[(N > 1) ? 1 : 0].score))
        else $error("head entries out of order");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("empty-frame result not marked last");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (drain_load && r_count <= stk_pkg::CNT_W'(1))
            |=> (r_count == '0 && r_state == ST_IDLE))
        else $error("drain finished with entries left");

    a_no_take_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> !ctl.ins)
        else $error("insert during drain");

endmodule
